### src/card_id_whitelist_table_macros.svh
// Assertion helpers for the card ID whitelist table checker.
`ifndef CARD_ID_WHITELIST_TABLE_MACROS_SVH
`define CARD_ID_WHITELIST_TABLE_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define CIDWL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CIDWL_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cidwl_pkg.sv
package cidwl_pkg;

   localparam int ID_W    = 48;
   localparam int KEY_W   = 2 * ID_W;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 3;
   localparam int CNT_W   = 5;
   localparam int RSP_W   = 8;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [KEY_W-1:0]  key_type;

   localparam kind_type KIND_SAVE  = 2'd0;
   localparam kind_type KIND_CLEAR = 2'd1;
   localparam kind_type KIND_CHECK = 2'd2;

   localparam status_type STATUS_SAVED   = 3'd0;
   localparam status_type STATUS_FULL    = 3'd1;
   localparam status_type STATUS_CLEARED = 3'd2;
   localparam status_type STATUS_MATCH   = 3'd3;
   localparam status_type STATUS_NOMATCH = 3'd4;

   localparam count_type LIMIT_RESET = 5'd10;

endpackage

### src/card_id_whitelist_table.sv
// Card ID whitelist table: a list of 96-bit card IDs with a stored count.
// req channel: tuser = kind (save, clear, check), tdata = id_high then id_low.
// rsp channel: tuser = status, tdata = card count after the request.
// csr channel: writes card_limit (5 bits); write only while the block is idle.
// Save appends at the count unless count >= min(card_limit, CAPACITY);
// clear zeroes the count, entries stay stale; check walks entries 0..count-1.
// IDs live in one synchronous RAM (CAPACITY x 96 bits, registered read).
// Save, clear, unknown kinds and a check on an empty list go from accept to
// the DONE state and then to the output register; a check on a nonempty list
// first runs the SCAN state, one RAM read a cycle, until a hit or the last entry.
// One request is in flight at a time; req_tready is high only when idle, so
// the next request is taken only after the last one leaves the DONE state.
// The finished response sits in an output register; if rsp_tready is low the
// response holds there and the next request may already be accepted and run,
// its result waiting internally until the output register frees up.
// Reset (synchronous, active high): count 0, card_limit 10, both channels
// empty. The RAM is not cleared; only counted (written) entries are compared.
module card_id_whitelist_table #(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // config write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  cidwl_pkg::count_type     csr_data,     // [4:0] card_limit
   // requests
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  cidwl_pkg::key_type       req_tdata,    // [47:0] id_high, [95:48] id_low
   input  cidwl_pkg::kind_type      req_tuser,    // [1:0] kind
   // responses
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,    // [4:0] card_count, [7:5] zero
   output cidwl_pkg::status_type    rsp_tuser     // [2:0] status
);
   import cidwl_pkg::*;

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SCAN_W = IDX_W + 1;
   localparam logic [6:0] CAP_V = 7'(CAPACITY);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // ID storage: entry n = {id_low, id_high}
   key_type card_mem [CAPACITY];

   logic [1:0]        state_ff, state_in;
   count_type         count_ff, count_in;
   count_type         limit_ff;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   key_type           key_ff;
   key_type           rd_ff;
   status_type        res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   count_type         rsp_count_ff;

   logic              req_fire;
   logic              list_full;
   logic              mem_we;
   logic [IDX_W-1:0]  rd_addr;
   logic              out_free;
   logic              scan_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // full when count reaches the smaller of card_limit and CAPACITY
   assign list_full = (count_ff >= limit_ff) || (7'(count_ff) >= CAP_V);
   assign mem_we    = req_fire && (req_tuser == KIND_SAVE) && !list_full;
   // scan_ff names the entry now in rd_ff; is it the last counted one?
   assign scan_last = (7'(scan_ff) + 7'd1) >= 7'(count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      res_in   = res_ff;
      rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DONE;
               scan_in  = '0;
               case (req_tuser)
                  KIND_SAVE: begin
                     if (list_full) begin
                        res_in = STATUS_FULL;
                     end else begin
                        res_in   = STATUS_SAVED;
                        count_in = count_ff + 5'd1;
                     end
                  end
                  KIND_CLEAR: begin
                     res_in   = STATUS_CLEARED;
                     count_in = '0;
                  end
                  KIND_CHECK: begin
                     res_in = STATUS_NOMATCH;
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;   // entry 0 read issued this cycle
                     end
                  end
                  default: begin
                     res_in = STATUS_NOMATCH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_addr = IDX_W'(scan_ff + SCAN_W'(1));
            if (rd_ff == key_ff) begin
               res_in   = STATUS_MATCH;
               state_in = ST_DONE;
            end else if (scan_last) begin
               res_in   = STATUS_NOMATCH;
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // RAM: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         card_mem[IDX_W'(count_ff)] <= req_tdata;
      end
      rd_ff <= card_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      res_ff  <= res_in;
      if (req_fire) begin
         key_ff <= req_tdata;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_status_ff <= res_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_W - CNT_W)'(0), rsp_count_ff};

endmodule

### src/cidwl_checker.sv
`include "card_id_whitelist_table_macros.svh"

module cidwl_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [7:0]            rsp_tdata,
   input cidwl_pkg::status_type rsp_tuser
);
   import cidwl_pkg::*;

   // stalled response holds
   `CIDWL_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")

   // one request in flight: ready drops right after an accept
   `CIDWL_ASSERT_NXT(a_one_inflight, req_tvalid && req_tready, !req_tready,
      "request accepted while another in flight")

   // a clear always reports an empty list
   `CIDWL_ASSERT_NOW(a_clear_zero, rsp_tvalid && rsp_tuser == STATUS_CLEARED,
      rsp_tdata == 8'd0, "cleared with nonzero count")

   // a save leaves at least one entry; status codes stay in range
   `CIDWL_ASSERT_NOW(a_save_count, rsp_tvalid && rsp_tuser == STATUS_SAVED,
      rsp_tdata[4:0] != 5'd0, "saved with zero count")

   `CIDWL_ASSERT_NOW(a_status_range, rsp_tvalid,
      rsp_tuser <= STATUS_NOMATCH && rsp_tdata[7:5] == 3'd0, "bad status or padding")

endmodule

bind card_id_whitelist_table cidwl_checker u_cidwl_checker (.*);
